### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is asserted.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset cycles included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// Types, status codes and the mixing table of the remote frame descrambler.
// ----------------------------------------------------------------------------
`default_nettype none

package rfd_pkg;

    localparam int IN_W  = 80;   // 76 field bits, padded to whole bytes
    localparam int OUT_W = 56;   // 54 field bits, padded to whole bytes

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SHAPE  = 2'd1;
    localparam logic [1:0] ST_LENGTH = 2'd2;

    localparam logic [3:0] ROWS_OK   = 4'd2;
    localparam logic [9:0] LEN_SHORT = 10'd52;
    localparam logic [9:0] LEN_LONG  = 10'd72;

    localparam logic [7:0] MIX_ADD   = 8'h25;
    localparam logic [7:0] MASK_LO   = 8'h07;
    localparam logic [7:0] MASK_HI   = 8'he0;
    localparam logic [7:0] MASK_NIB  = 8'h0f;
    localparam logic [3:0] NIB_ONES  = 4'hf;

    // One item in flight: status, plain fields and the six payload bytes.
    typedef struct packed {
        logic [1:0]      status;
        logic [3:0]      button;
        logic [3:0]      repeat_count;
        logic [5:0][7:0] bytes;
    } t_item;

    function automatic logic [7:0] mix_lut(input logic [4:0] idx);
        logic [7:0] r;
        case (idx)
            5'd0:  r = 8'd25;
            5'd1:  r = 8'd5;
            5'd2:  r = 8'd63;
            5'd3:  r = 8'd97;
            5'd4:  r = 8'd203;
            5'd5:  r = 8'd109;
            5'd6:  r = 8'd69;
            5'd7:  r = 8'd10;
            5'd8:  r = 8'd3;
            5'd9:  r = 8'd7;
            5'd10: r = 8'd64;
            5'd11: r = 8'd5;
            5'd12: r = 8'd71;
            5'd13: r = 8'd134;
            5'd14: r = 8'd180;
            5'd15: r = 8'd74;
            5'd16: r = 8'd41;
            5'd17: r = 8'd158;
            5'd18: r = 8'd102;
            5'd19: r = 8'd199;
            5'd20: r = 8'd93;
            5'd21: r = 8'd118;
            5'd22: r = 8'd175;
            5'd23: r = 8'd101;
            5'd24: r = 8'd60;
            5'd25: r = 8'd77;
            5'd26: r = 8'd143;
            5'd27: r = 8'd174;
            5'd28: r = 8'd103;
            5'd29: r = 8'd148;
            5'd30: r = 8'd29;
            default: r = 8'd85;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### src/remote_frame_descrambler_core.sv
// ----------------------------------------------------------------------------
// remote_frame_descrambler_core
// Gate-remote frame descrambler: shape check, payload unscramble, field split.
// ----------------------------------------------------------------------------
//  channel  dir  bits  contents (lowest bit first)
//  s_axis   in   80    frame_bits 52, row_count 4, first_row_length 10,
//                      second_row_length 10, zero pad 4
//  m_axis   out  56    status 2, button 4, repeat_count 4, serial_number 28,
//                      rolling_code 16, zero pad 2
//
//  Three register stages: unpack/permute, round zero, round one. Every stage
//  takes a word per cycle, so one frame enters each cycle while the output
//  is not held; a result passes the three registers in that order.
//  Each stage has its own valid bit and holds its word while the next stage
//  is full and stalled; bubbles collapse, nothing is dropped or repeated.
//  Reset (synchronous, active low) clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module remote_frame_descrambler_core (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // frame_bits[51:0], row_count[55:52], first_row_length[65:56],
    // second_row_length[75:66], pad[79:76]
    input  wire logic [rfd_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  wire logic                      i_m_axis_tready,
    // status[1:0], button[5:2], repeat_count[9:6], serial_number[37:10],
    // rolling_code[53:38], pad[55:54]
    output logic [rfd_pkg::OUT_W-1:0]      o_m_axis_tdata
);
    import rfd_pkg::*;

    logic  s1_valid;
    logic  s1_ready;
    t_item s1_item;
    logic  s2_valid;
    logic  s2_ready;
    t_item s2_item;
    logic  s3_valid;
    t_item s3_item;

    logic [27:0] serial;
    logic [15:0] code;
    logic [3:0]  button;
    logic [3:0]  repeat_cnt;

    // Stage one: shape and length check, invert and permute bytes.
    rfd_unpack u_unpack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_item  (s1_item)
    );

    // Stage two: round zero, ends with a swap of bytes zero and one.
    rfd_round u_round0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_swap  (1'b1),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_item  (s1_item),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_item  (s2_item)
    );

    // Stage three: round one, no swap; its register is the output register.
    rfd_round u_round1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_swap  (1'b0),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_item  (s2_item),
        .o_valid (s3_valid),
        .i_ready (i_m_axis_tready),
        .o_item  (s3_item)
    );

    // Drop all payload fields of a rejected frame to zero.
    always_comb begin
        if (s3_item.status == ST_OK) begin
            button     = s3_item.button;
            repeat_cnt = s3_item.repeat_count;
            serial     = {s3_item.bytes[5][3:0], s3_item.bytes[4],
                          s3_item.bytes[3], s3_item.bytes[2]};
            code       = {s3_item.bytes[1], s3_item.bytes[0]};
        end else begin
            button     = 4'd0;
            repeat_cnt = 4'd0;
            serial     = 28'd0;
            code       = 16'd0;
        end
    end

    assign o_m_axis_tvalid = s3_valid;
    assign o_m_axis_tdata  = {2'b00, code, serial, repeat_cnt, button, s3_item.status};

endmodule

`default_nettype wire

### src/rfd_unpack.sv
// ----------------------------------------------------------------------------
// rfd_unpack
// First stage: check the frame shape, invert and permute the payload bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_unpack (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [rfd_pkg::IN_W-1:0] i_data,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output rfd_pkg::t_item             o_item
);
    import rfd_pkg::*;

    logic [51:0] frame;
    logic [51:0] inv;
    logic [3:0]  rows;
    logic [9:0]  len0;
    logic [9:0]  len1;
    t_item       n_item;
    t_item       r_item;
    logic        r_valid;

    assign frame = i_data[51:0];
    assign rows  = i_data[55:52];
    assign len0  = i_data[65:56];
    assign len1  = i_data[75:66];
    assign inv   = ~frame;

    always_comb begin
        if (rows != ROWS_OK || len1 != 10'd0) begin
            n_item.status = ST_SHAPE;
        end else if (len0 != LEN_SHORT && len0 != LEN_LONG) begin
            n_item.status = ST_LENGTH;
        end else begin
            n_item.status = ST_OK;
        end
        n_item.button       = inv[51:48];
        n_item.repeat_count = inv[47:44] ^ inv[51:48] ^ NIB_ONES;
        // Inversion of the received bits and the inverting permutation
        // cancel for the five full bytes; the top nibble byte keeps ones above.
        n_item.bytes[0] = frame[39:32];
        n_item.bytes[1] = frame[31:24];
        n_item.bytes[2] = frame[7:0];
        n_item.bytes[3] = frame[15:8];
        n_item.bytes[4] = frame[23:16];
        n_item.bytes[5] = {NIB_ONES, frame[43:40]};
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

### src/rfd_round.sv
// ----------------------------------------------------------------------------
// rfd_round
// One unscramble round: two table lookups with masking, optional byte swap.
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_round (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_swap,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire rfd_pkg::t_item i_item,
    output logic                o_valid,
    input  wire logic           i_ready,
    output rfd_pkg::t_item      o_item
);
    import rfd_pkg::*;

    logic [7:0]      t1;
    logic [7:0]      t2;
    logic [5:0][7:0] b1;
    logic [5:0][7:0] b2;
    t_item           n_item;
    t_item           r_item;
    logic            r_valid;

    always_comb begin
        // First lookup keyed by the top five bits of byte zero.
        t1 = mix_lut(i_item.bytes[0][7:3]) + MIX_ADD;
        b1 = i_item.bytes;
        for (int i = 1; i < 6; i++) begin
            b1[i] = i_item.bytes[i] ^ t1;
        end
        b1[5] = b1[5] & MASK_NIB;
        b1[0] = i_item.bytes[0] ^ (t1 & MASK_LO);

        // Second lookup keyed by the low five bits of the updated byte zero.
        t2 = mix_lut(b1[0][4:0]);
        b2 = b1;
        for (int i = 1; i < 6; i++) begin
            b2[i] = b1[i] ^ t2;
        end
        b2[5] = b2[5] & MASK_NIB;
        b2[0] = b1[0] ^ (t2 & MASK_HI);

        n_item = i_item;
        n_item.bytes = b2;
        if (i_swap) begin
            n_item.bytes[0] = b2[1];
            n_item.bytes[1] = b2[0];
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

### src/rfd_checker.sv
// ----------------------------------------------------------------------------
// rfd_checker
// Port-level checks of the descrambler core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rfd_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_s_axis_tready,
    input wire logic                      o_m_axis_tvalid,
    input wire logic                      i_m_axis_tready,
    input wire logic [rfd_pkg::OUT_W-1:0] o_m_axis_tdata
);
    import rfd_pkg::*;

    // A stalled result holds.
    `ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata),
        "stalled result changed")

    // An empty output stage always lets the input take a word.
    `ASSERT_CLK_RST(a_empty_ready, i_clk, i_rst_n, !o_m_axis_tvalid |-> o_s_axis_tready,
        "empty pipeline not ready")

    // Rejected frames carry only their status.
    `ASSERT_CLK_RST(a_reject_zero, i_clk, i_rst_n,
        o_m_axis_tvalid && (o_m_axis_tdata[1:0] != ST_OK) |-> (o_m_axis_tdata[55:2] == 54'd0),
        "rejected frame has payload")

    // Status is one of the three defined codes.
    `ASSERT_CLK_RST(a_status_code, i_clk, i_rst_n,
        o_m_axis_tvalid |-> (o_m_axis_tdata[1:0] == ST_OK || o_m_axis_tdata[1:0] == ST_SHAPE
                             || o_m_axis_tdata[1:0] == ST_LENGTH),
        "undefined status code")

    // Reset empties the output.
    `ASSERT_CLK(a_reset_empty, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")

endmodule

bind remote_frame_descrambler_core rfd_checker u_rfd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
